### src/dps_pkg.sv
// Package: widths and types shared by the path simplifier.
`timescale 1ns / 1ps
`default_nettype none
package dps_pkg;
	localparam int MAX_POINTS  = 64;
	localparam int PT_IDX_W    = $clog2(MAX_POINTS);
	localparam int PT_CNT_W    = PT_IDX_W + 1;
	localparam int COORD_W     = 14;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int SQ_FULL_W   = 2 * CROSS_W;
	localparam int SCORE_W     = 60;
	localparam int DSQ_W       = 2 * DIFF_W - 1;
	localparam int DLEN_W      = DSQ_W + 2;
	localparam int TOL_W       = 14;
	localparam int TOL2_W      = 2 * TOL_W;
	localparam int LIMIT_W     = TOL2_W + DLEN_W;
	localparam int STACK_DEPTH = 128;
	localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
	localparam int STACK_PTR_W = STACK_IDX_W + 1;
	localparam int PT_W        = 3 * COORD_W;
	localparam int TDATA_W     = ((PT_W + 7) / 8) * 8;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(50);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;
endpackage
`default_nettype wire

### src/douglas_peucker_path_simplifier.sv
// Top level: 3D polyline simplifier with point store and segment stack.
// Usage:
//  s_axis carries one path point per word: tdata = {z, y, x}, x from bit 0 up,
//  tlast marks the final point of a path. Points are written into a 64-entry
//  store at one word per cycle; words past 64 are dropped and flagged.
//  After the tlast word the block thins the path and stops taking input
//  until the last kept point has left on m_axis.
//  Each segment runs setup states ST_SEG_A to ST_SEG_F, scans its inner
//  points at one per cycle through the single point store read port,
//  lets the scan pipeline drain and decides; a split with stack room
//  pushes start, far, far, end, and each pop runs ST_POP1 to ST_POP3.
//  Output: each kept point is read, registered and held until tready;
//  each point that is not kept is skipped after its read.
//  m_axis holds a word stable until tready; a stalled receiver just
//  stretches the emit phase.
//  cfg_we/cfg_wdata writes the tolerance (reset 50); write only when idle.
//  Reset (arst_n low) clears counters and sets the tolerance to 50; keep
//  marks are rewritten as each point loads. The block comes up ready for
//  the first point.
`timescale 1ns / 1ps
`default_nettype none
module douglas_peucker_path_simplifier (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [dps_pkg::TOL_W-1:0]       cfg_wdata,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire  [dps_pkg::TDATA_W-1:0]     s_axis_tdata,  // coord_x, coord_y, coord_z, zero pad
	input  wire                             s_axis_tlast,  // final_point
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	output logic [dps_pkg::TDATA_W-1:0]     m_axis_tdata,  // out_x, out_y, out_z, zero pad
	output logic                            m_axis_tlast,  // end_of_path
	output logic [1:0]                      m_axis_tuser   // was_reduced, overflowed
);
	import dps_pkg::*;

	typedef enum logic [4:0] {
		ST_LOAD, ST_START, ST_SEG_A, ST_SEG_B, ST_SEG_C, ST_SEG_D, ST_SEG_E,
		ST_SEG_F, ST_SCAN, ST_DECIDE, ST_PUSH, ST_POP1, ST_POP2, ST_POP3,
		ST_EMIT, ST_EMIT_RD, ST_EMIT_HOLD
	} state_t;

	state_t state_q;

	logic [TOL_W-1:0]        tol_q;
	logic [TOL2_W-1:0]       tol2_q;
	logic [PT_CNT_W-1:0]     count_q;
	logic [PT_CNT_W-1:0]     n_q;
	logic                    dropped_q;
	logic                    reduced_q;
	logic [PT_IDX_W-1:0]     seg_start_q, seg_end_q, far_q;
	logic [PT_CNT_W-1:0]     idx_q;
	logic [PT_CNT_W-1:0]     emit_q;
	logic [STACK_PTR_W-1:0]  sp_q;
	logic [1:0]              push_q;
	logic [SCORE_W-1:0]      best_q;
	logic [LIMIT_W-1:0]      limit_q;
	logic [DLEN_W-1:0]       dlen2_q;
	logic                    zero_d_q;
	point_t                  a_q;
	logic signed [DIFF_W-1:0] d_q [3];
	logic [DSQ_W-1:0]        dsq_q [3];

	// point store
	point_t                  pt_mem [MAX_POINTS];
	point_t                  pt_rd;
	logic [PT_IDX_W-1:0]     pt_ra;
	logic                    pt_we;

	// keep marks, read at the point store address
	logic                    keep_mem [MAX_POINTS];
	logic                    keep_rd;
	logic [PT_IDX_W-1:0]     keep_wa;
	logic                    keep_wd;
	logic                    keep_we;

	// segment stack
	logic [PT_IDX_W-1:0]     stk_mem [STACK_DEPTH];
	logic [PT_IDX_W-1:0]     stk_rd;
	logic [STACK_IDX_W-1:0]  stk_ra;
	logic [PT_IDX_W-1:0]     stk_wd;
	logic                    stk_we;

	logic                    in_acc;
	logic                    scan_issue;
	logic                    emit_sel;
	logic                    pipe_busy;
	logic                    split;

	// scan pipeline
	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [PT_IDX_W-1:0]     idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [DIFF_W-1:0]  v_s2 [3];
	logic signed [CROSS_W-1:0] c_s3 [3];
	logic [SCORE_W-1:0]      q_s4 [3];
	logic [SCORE_W-1:0]      sum_s5;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign pt_we         = in_acc && (count_q < PT_CNT_W'(MAX_POINTS));
	assign scan_issue    = (state_q == ST_SCAN) && (idx_q < {1'b0, seg_end_q});
	assign emit_sel      = !reduced_q || keep_rd;
	assign pipe_busy     = vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5;
	assign split         = best_q > SCORE_W'(limit_q);

	always_comb begin
		unique case (state_q)
			ST_SEG_A: pt_ra = seg_start_q;
			ST_SEG_B: pt_ra = seg_end_q;
			ST_SCAN:  pt_ra = idx_q[PT_IDX_W-1:0];
			default:  pt_ra = emit_q[PT_IDX_W-1:0];
		endcase
	end

	// the first point of a path is always an endpoint; the last one is marked at start
	always_comb begin
		unique case (state_q)
			ST_START:  keep_wa = PT_IDX_W'(n_q - PT_CNT_W'(1));
			ST_DECIDE: keep_wa = far_q;
			default:   keep_wa = count_q[PT_IDX_W-1:0];
		endcase
	end
	assign keep_we = pt_we || (state_q == ST_START) || ((state_q == ST_DECIDE) && split);
	assign keep_wd = (state_q == ST_LOAD) ? (count_q == '0) : 1'b1;

	always_comb begin
		unique case (push_q)
			2'd0:    stk_wd = seg_start_q;
			2'd3:    stk_wd = seg_end_q;
			default: stk_wd = far_q;
		endcase
	end
	assign stk_we = (state_q == ST_PUSH);
	assign stk_ra = (state_q == ST_POP1) ? STACK_IDX_W'(sp_q - STACK_PTR_W'(1))
	                                     : STACK_IDX_W'(sp_q - STACK_PTR_W'(2));

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[count_q[PT_IDX_W-1:0]] <= point_t'(s_axis_tdata[PT_W-1:0]);
		end
		pt_rd <= pt_mem[pt_ra];
	end

	always_ff @(posedge clk) begin
		if (keep_we) begin
			keep_mem[keep_wa] <= keep_wd;
		end
		keep_rd <= keep_mem[pt_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[sp_q[STACK_IDX_W-1:0]] <= stk_wd;
		end
		stk_rd <= stk_mem[stk_ra];
	end

	// tolerance register and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end
	always_ff @(posedge clk) begin
		tol2_q <= tol_q * tol_q;
	end

	// scan pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= scan_issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// scan pipeline payload: v = p - a, cross (or v itself), squares, sum
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[PT_IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
		v_s2[0] <= DIFF_W'(pt_rd.x) - DIFF_W'(a_q.x);
		v_s2[1] <= DIFF_W'(pt_rd.y) - DIFF_W'(a_q.y);
		v_s2[2] <= DIFF_W'(pt_rd.z) - DIFF_W'(a_q.z);
		if (zero_d_q) begin
			for (int k = 0; k < 3; k++) begin
				c_s3[k] <= CROSS_W'(v_s2[k]);
			end
		end else begin
			c_s3[0] <= CROSS_W'(v_s2[1] * d_q[2]) - CROSS_W'(v_s2[2] * d_q[1]);
			c_s3[1] <= CROSS_W'(v_s2[2] * d_q[0]) - CROSS_W'(v_s2[0] * d_q[2]);
			c_s3[2] <= CROSS_W'(v_s2[0] * d_q[1]) - CROSS_W'(v_s2[1] * d_q[0]);
		end
		for (int k = 0; k < 3; k++) begin
			q_s4[k] <= SCORE_W'(SQ_FULL_W'(c_s3[k] * c_s3[k]));
		end
		sum_s5 <= q_s4[0] + q_s4[1] + q_s4[2];
	end

	// segment setup datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_SEG_B) begin
			a_q <= pt_rd;
		end
		if (state_q == ST_SEG_C) begin
			d_q[0] <= DIFF_W'(pt_rd.x) - DIFF_W'(a_q.x);
			d_q[1] <= DIFF_W'(pt_rd.y) - DIFF_W'(a_q.y);
			d_q[2] <= DIFF_W'(pt_rd.z) - DIFF_W'(a_q.z);
		end
		for (int k = 0; k < 3; k++) begin
			dsq_q[k] <= DSQ_W'(d_q[k] * d_q[k]);
		end
		dlen2_q <= DLEN_W'(dsq_q[0]) + DLEN_W'(dsq_q[1]) + DLEN_W'(dsq_q[2]);
		if (state_q == ST_SEG_F) begin
			zero_d_q <= (dlen2_q == '0);
			limit_q  <= (dlen2_q == '0) ? LIMIT_W'(tol2_q) : LIMIT_W'(tol2_q * dlen2_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			count_q       <= '0;
			n_q           <= '0;
			dropped_q     <= 1'b0;
			reduced_q     <= 1'b0;
			seg_start_q   <= '0;
			seg_end_q     <= '0;
			far_q         <= '0;
			idx_q         <= '0;
			emit_q        <= '0;
			sp_q          <= '0;
			push_q        <= '0;
			best_q        <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tlast  <= 1'b0;
			m_axis_tuser  <= '0;
		end else begin
			if (vld_s5 && (sum_s5 > best_q)) begin
				best_q <= sum_s5;
				far_q  <= idx_s5;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (pt_we) begin
							count_q <= count_q + PT_CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							n_q     <= pt_we ? count_q + PT_CNT_W'(1) : count_q;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					reduced_q <= (n_q >= PT_CNT_W'(3));
					emit_q    <= '0;
					sp_q      <= '0;
					if (n_q >= PT_CNT_W'(3)) begin
						seg_start_q <= '0;
						seg_end_q   <= PT_IDX_W'(n_q - PT_CNT_W'(1));
						state_q     <= ST_SEG_A;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SEG_A: state_q <= ST_SEG_B;
				ST_SEG_B: state_q <= ST_SEG_C;
				ST_SEG_C: state_q <= ST_SEG_D;
				ST_SEG_D: state_q <= ST_SEG_E;
				ST_SEG_E: state_q <= ST_SEG_F;
				ST_SEG_F: begin
					best_q  <= '0;
					idx_q   <= {1'b0, seg_start_q} + PT_CNT_W'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						idx_q <= idx_q + PT_CNT_W'(1);
					end else if (!pipe_busy) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					push_q <= '0;
					if (split) begin
						state_q <= (sp_q <= STACK_PTR_W'(STACK_DEPTH - 4)) ? ST_PUSH : ST_POP1;
					end else begin
						state_q <= ST_POP1;
					end
				end
				ST_PUSH: begin
					sp_q   <= sp_q + STACK_PTR_W'(1);
					push_q <= push_q + 2'd1;
					if (push_q == 2'd3) begin
						state_q <= ST_POP1;
					end
				end
				ST_POP1: begin
					state_q <= (sp_q < STACK_PTR_W'(2)) ? ST_EMIT : ST_POP2;
				end
				ST_POP2: begin
					seg_end_q <= stk_rd;
					state_q   <= ST_POP3;
				end
				ST_POP3: begin
					seg_start_q <= stk_rd;
					sp_q        <= sp_q - STACK_PTR_W'(2);
					state_q     <= ST_SEG_A;
				end
				ST_EMIT: begin
					if (emit_q >= n_q) begin
						count_q   <= '0;
						sp_q      <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_LOAD;
					end else begin
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					if (emit_sel) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= TDATA_W'(pt_rd);
						m_axis_tlast  <= (emit_q == n_q - PT_CNT_W'(1));
						m_axis_tuser  <= {dropped_q, reduced_q};
						state_q       <= ST_EMIT_HOLD;
					end else begin
						emit_q  <= emit_q + PT_CNT_W'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT_HOLD: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						emit_q        <= emit_q + PT_CNT_W'(1);
						state_q       <= ST_EMIT;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= STACK_PTR_W'(STACK_DEPTH))
		else $error("segment stack pointer beyond depth");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PT_CNT_W'(MAX_POINTS))
		else $error("point count beyond store size");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser)))
		else $error("output word changed while stalled");
	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while a run is emitted");
endmodule
`default_nettype wire
